[rtl/kbq_pkg.sv]
// Shared definitions for the keyboard controller byte queue: queue sizing,
// request and status codes, the enable packet bytes and pointer arithmetic.
// No dependencies.
package kbq_pkg;

    // Queue sizing. Valid range is 8 to 256 entries.
    localparam int QUEUE_DEPTH = 16;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    // The enable packet is five bytes; a key event can add one more byte.
    localparam int PKT_LEN  = 5;
    localparam int MAX_PUSH = PKT_LEN + 1;

    // Port widths.
    localparam int S_TDATA_W = 16;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 16;
    localparam int M_TUSER_W = 2;

    // Enable packet bytes. The last byte is the XOR of the first four, with
    // bits 7 and 6 flipped when bit 7 of that XOR is set.
    localparam logic [7:0] PKT_HEADER = 8'h80;
    localparam logic [7:0] PKT_CMD    = 8'hA8;
    localparam logic [7:0] PKT_ZERO   = 8'h00;
    localparam logic [7:0] PKT_FOLD   = 8'hC0;
    localparam logic [7:0] PKT_XOR    = PKT_HEADER ^ PKT_CMD ^ PKT_ZERO ^ PKT_ZERO;
    localparam logic [7:0] PKT_CHECK  = PKT_XOR[7] ? (PKT_XOR ^ PKT_FOLD) : PKT_XOR;

    // Request codes carried on the input channel.
    typedef enum logic [2:0] {
        REQ_ARM   = 3'd0,
        REQ_KEY   = 3'd1,
        REQ_READ  = 3'd2,
        REQ_QUERY = 3'd3,
        REQ_RESET = 3'd4
    } req_t;

    // Status codes returned with every result.
    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_OVERFLOW = 2'd1,
        ST_EMPTY    = 2'd2
    } status_t;

    // Byte at a given position of the enable packet.
    function automatic logic [7:0] pkt_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = PKT_HEADER;
            3'd1:    b = PKT_CMD;
            3'd2:    b = PKT_ZERO;
            3'd3:    b = PKT_ZERO;
            3'd4:    b = PKT_CHECK;
            default: b = PKT_ZERO;
        endcase
        return b;
    endfunction

    // Pointer advance modulo the queue depth; inc is always below the depth.
    function automatic logic [PTR_W-1:0] ptr_add(input logic [PTR_W-1:0] ptr,
                                                 input logic [PTR_W-1:0] inc);
        logic [PTR_W:0] sum;
        sum = {1'b0, ptr} + {1'b0, inc};
        if (sum >= (PTR_W + 1)'(QUEUE_DEPTH)) begin
            sum = sum - (PTR_W + 1)'(QUEUE_DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

endpackage

[rtl/keyboard_ctrl_byte_queue.sv]
// Keyboard controller byte queue, serial receive side: top level.
// Depends on kbq_pkg for sizing, codes, packet bytes and pointer arithmetic.
// Holds the input register, the queue, the request decode and the result register.

// Usage: each request (arm, key event, read, query, reset) enters on the s_
// channel and produces exactly one result transaction on the m_ channel, in
// order. The block takes one request per clock cycle. A request is held in the
// input register and its result is then loaded into the result register, which
// drives m_tvalid. The only thing that slows the stream is back-pressure on
// m_tready. The first arm or key event after reset queues the enable packet
// 80 A8 00 00 28 ahead of any scancode. The queue holds kbq_pkg::QUEUE_DEPTH
// bytes; bytes pushed onto a full queue are dropped and the result reports an
// overflow status. Reading an empty queue returns zero with an empty status.
// The result's irq_assert and irq_clear bits tell the host when to raise or
// drop its receive interrupt.
module keyboard_ctrl_byte_queue (
    input  logic                           aclk,
    input  logic                           aresetn,
    // Request channel.
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // s_tdata: [7:0] scancode, [8] key_up, [15:9] zero.
    input  logic [kbq_pkg::S_TDATA_W-1:0]  s_tdata,
    // s_tuser: [2:0] req_type.
    input  logic [kbq_pkg::S_TUSER_W-1:0]  s_tuser,
    // Result channel.
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // m_tdata: [7:0] read_data, [8] has_byte, [9] irq_assert, [10] irq_clear,
    // [15:11] zero.
    output logic [kbq_pkg::M_TDATA_W-1:0]  m_tdata,
    // m_tuser: [1:0] status.
    output logic [kbq_pkg::M_TUSER_W-1:0]  m_tuser
);

    localparam int PTR_W    = kbq_pkg::PTR_W;
    localparam int CNT_W    = kbq_pkg::CNT_W;
    localparam int MAX_PUSH = kbq_pkg::MAX_PUSH;

    // Input register.
    logic       in_vld_reg;
    logic [2:0] in_req_reg;
    logic [7:0] in_code_reg;
    logic       in_up_reg;

    // Queue state. The storage has no reset; only written entries are read.
    logic [7:0]       store_reg [kbq_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] head_reg;
    logic [PTR_W-1:0] head_next;
    logic [PTR_W-1:0] tail_reg;
    logic [PTR_W-1:0] tail_next;
    logic [CNT_W-1:0] fill_reg;
    logic [CNT_W-1:0] fill_next;
    logic             en_reg;
    logic             en_next;

    // Result register.
    logic                 m_vld_reg;
    logic [7:0]           out_data_reg;
    logic [7:0]           out_data_next;
    logic                 out_has_reg;
    logic                 out_set_reg;
    logic                 out_set_next;
    logic                 out_clr_reg;
    logic                 out_clr_next;
    kbq_pkg::status_t     out_st_reg;
    kbq_pkg::status_t     out_st_next;

    // Handshake control.
    logic s_accept;
    logic out_ready;
    logic process;

    // Push staging.
    logic [7:0]       push_byte [MAX_PUSH];
    logic [CNT_W-1:0] push_cnt;
    logic [CNT_W-1:0] push_space;
    logic [CNT_W-1:0] push_done;
    logic             push_drop;
    logic [7:0]       key_byte;
    logic [PTR_W-1:0] wr_idx [MAX_PUSH];
    logic             wr_en  [MAX_PUSH];
    kbq_pkg::req_t    req;

    // The input register frees up whenever its item moves into the result
    // register, so one request per cycle flows as long as m_tready is high.
    assign out_ready = !m_vld_reg || m_tready;
    assign process   = in_vld_reg && out_ready;
    assign s_tready  = !in_vld_reg || out_ready;
    assign s_accept  = s_tvalid && s_tready;

    assign req      = kbq_pkg::req_t'(in_req_reg);
    assign key_byte = {in_code_reg[7] | in_up_reg, in_code_reg[6:0]};

    // Build the list of bytes this request pushes: the enable packet when not
    // yet enabled, then the scancode for a key event.
    always_comb begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            push_byte[i] = key_byte;
        end
        push_cnt = '0;
        if ((req == kbq_pkg::REQ_ARM) || (req == kbq_pkg::REQ_KEY)) begin
            if (!en_reg) begin
                for (int i = 0; i < kbq_pkg::PKT_LEN; i++) begin
                    push_byte[i] = kbq_pkg::pkt_byte(3'(i));
                end
                push_cnt = CNT_W'(kbq_pkg::PKT_LEN);
            end
            if (req == kbq_pkg::REQ_KEY) begin
                push_cnt = push_cnt + CNT_W'(1);
            end
        end
    end

    // Bytes that do not fit are dropped; those that fit go in order.
    assign push_space = CNT_W'(kbq_pkg::QUEUE_DEPTH) - fill_reg;
    assign push_drop  = push_cnt > push_space;
    assign push_done  = push_drop ? push_space : push_cnt;

    always_comb begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            wr_idx[i] = kbq_pkg::ptr_add(tail_reg, PTR_W'(i));
            wr_en[i]  = process && (CNT_W'(i) < push_done);
        end
    end

    // Request decode and next state.
    always_comb begin
        head_next     = head_reg;
        tail_next     = tail_reg;
        fill_next     = fill_reg;
        en_next       = en_reg;
        out_data_next = '0;
        out_set_next  = 1'b0;
        out_clr_next  = 1'b0;
        out_st_next   = kbq_pkg::ST_OK;
        case (req)
            kbq_pkg::REQ_ARM, kbq_pkg::REQ_KEY: begin
                tail_next = kbq_pkg::ptr_add(tail_reg, push_done[PTR_W-1:0]);
                fill_next = fill_reg + push_done;
                en_next   = 1'b1;
                if (push_drop) begin
                    out_st_next = kbq_pkg::ST_OVERFLOW;
                end
                // An arm event only interrupts when bytes are waiting.
                out_set_next = (req == kbq_pkg::REQ_KEY) || (fill_next != '0);
            end
            kbq_pkg::REQ_READ: begin
                if (fill_reg == '0) begin
                    out_st_next = kbq_pkg::ST_EMPTY;
                end else begin
                    out_data_next = store_reg[head_reg];
                    head_next     = kbq_pkg::ptr_add(head_reg, PTR_W'(1));
                    fill_next     = fill_reg - CNT_W'(1);
                    out_set_next  = fill_next != '0;
                end
            end
            kbq_pkg::REQ_RESET: begin
                head_next    = '0;
                tail_next    = '0;
                fill_next    = '0;
                en_next      = 1'b0;
                out_clr_next = 1'b1;
            end
            default: begin
                // A query and the unused codes leave the state alone.
            end
        endcase
    end

    // Queue storage, written at up to MAX_PUSH consecutive slots per cycle.
    always_ff @(posedge aclk) begin
        for (int i = 0; i < MAX_PUSH; i++) begin
            if (wr_en[i]) begin
                store_reg[wr_idx[i]] <= push_byte[i];
            end
        end
    end

    // Control state, queue pointers and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_vld_reg <= 1'b0;
            m_vld_reg  <= 1'b0;
            head_reg   <= '0;
            tail_reg   <= '0;
            fill_reg   <= '0;
            en_reg     <= 1'b0;
        end else begin
            if (s_accept) begin
                in_vld_reg <= 1'b1;
            end else if (process) begin
                in_vld_reg <= 1'b0;
            end
            if (process) begin
                m_vld_reg <= 1'b1;
                head_reg  <= head_next;
                tail_reg  <= tail_next;
                fill_reg  <= fill_next;
                en_reg    <= en_next;
            end else if (m_tready) begin
                m_vld_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_req_reg  <= s_tuser[2:0];
            in_code_reg <= s_tdata[7:0];
            in_up_reg   <= s_tdata[8];
        end
        if (process) begin
            out_data_reg <= out_data_next;
            out_has_reg  <= fill_next != '0;
            out_set_reg  <= out_set_next;
            out_clr_reg  <= out_clr_next;
            out_st_reg   <= out_st_next;
        end
    end

    assign m_tvalid = m_vld_reg;
    assign m_tdata  = {5'b0, out_clr_reg, out_set_reg, out_has_reg, out_data_reg};
    assign m_tuser  = out_st_reg;

`ifndef SYNTHESIS
    // The fill count never exceeds the queue depth.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_reg <= CNT_W'(kbq_pkg::QUEUE_DEPTH))
        else $error("queue fill count above depth");

    // Tail pointer always sits fill_count entries past the head pointer.
    assert property (@(posedge aclk) disable iff (!aresetn)
        tail_reg == kbq_pkg::ptr_add(head_reg, fill_reg[PTR_W-1:0]))
        else $error("queue pointers disagree with fill count");

    // A result's has_byte bit reports the queue left behind by its request.
    assert property (@(posedge aclk) disable iff (!aresetn)
        process |=> (out_has_reg == (fill_reg != '0)))
        else $error("has_byte does not match queue fill");

    // An empty read returns zero data and never raises the interrupt.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_vld_reg && (out_st_reg == kbq_pkg::ST_EMPTY)) |->
            ((out_data_reg == '0) && !out_set_reg && !out_has_reg))
        else $error("empty read returned data or interrupt");
`endif

endmodule
